// File: rtl/idm_pkg.sv
// Package for the integer divide/modulo block: widths, opcodes, beat types,
// controller states and the control group that drives the divider cells.
// No dependencies.
package idm_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

   // sign bit and largest positive value at this width
   localparam logic [DATA_WIDTH-1:0] SIGN_MASK = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [DATA_WIDTH-1:0] MAX_POS   = ~SIGN_MASK;

   typedef enum logic {
      OP_UNSIGNED = 1'b0,
      OP_SIGNED   = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type            opcode;
      logic [DATA_WIDTH-1:0] dividend;
      logic [DATA_WIDTH-1:0] divisor;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] quotient;
      logic [DATA_WIDTH-1:0] remainder;
      logic                  divide_by_zero;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIX
   } state_type;

   // control shared by every cell of the divider row
   typedef struct packed {
      logic load;     // capture operand bits
      logic step;     // perform one shift/subtract iteration
      logic success;  // trial subtract did not borrow: keep difference
   } cell_ctrl_type;

endpackage

// File: rtl/idm_cell.sv
// One bit slice of the restoring divider: holds a remainder, quotient and
// divisor bit and ripples the trial-subtract borrow to its upper neighbor.
// Depends on idm_pkg.
module idm_cell (
   input  logic                   clock,
   input  idm_pkg::cell_ctrl_type ctrl,
   input  logic                   ld_quo,     // operand bit on load
   input  logic                   ld_div,     // divisor bit on load
   input  logic                   rem_in,     // shifted remainder bit from below
   input  logic                   quo_in,     // shifted quotient bit from below
   input  logic                   borrow_in,
   output logic                   rem_out,
   output logic                   quo_out,
   output logic                   borrow_out
);

   logic rem_ff, rem_in_nxt;
   logic quo_ff, quo_in_nxt;
   logic div_ff, div_in;
   logic diff;

   // trial subtract of the divisor bit from the shifted remainder bit
   assign diff       = rem_in ^ div_ff ^ borrow_in;
   assign borrow_out = (~rem_in & div_ff) | (~(rem_in ^ div_ff) & borrow_in);

   always_comb begin
      rem_in_nxt = rem_ff;
      quo_in_nxt = quo_ff;
      div_in     = div_ff;
      if (ctrl.load) begin
         rem_in_nxt = 1'b0;
         quo_in_nxt = ld_quo;
         div_in     = ld_div;
      end else if (ctrl.step) begin
         rem_in_nxt = ctrl.success ? diff : rem_in;
         quo_in_nxt = quo_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in_nxt;
      quo_ff <= quo_in_nxt;
      div_ff <= div_in;
   end

   assign rem_out = rem_ff;
   assign quo_out = quo_ff;

endmodule

// File: rtl/integer_divide_modulo.sv
// Integer divide/modulo, unsigned or signed truncating, one item at a time.
// Each item runs through the row of bit cells in ST_RUN, one quotient bit per cycle,
// then through a sign fix-up in ST_FIX, which writes the registered result.
// A new beat is taken only in idle, also while the last result still waits.
// Reset (synchronous, active high) returns to idle and drops rsp_valid.
module integer_divide_modulo (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  idm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output idm_pkg::rsp_type rsp_data
);

   localparam int W = idm_pkg::DATA_WIDTH;

   idm_pkg::state_type state_ff, state_in;
   logic [idm_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   idm_pkg::rsp_type          rsp_data_ff, rsp_data_in;
   logic                      neg_q_ff, neg_q_in;
   logic                      neg_r_ff, neg_r_in;
   logic                      dz_ff, dz_in;

   idm_pkg::cell_ctrl_type    ctrl;
   logic                      req_fire;
   logic                      in_signed, in_neg_a, in_neg_b, in_dz;
   logic [W-1:0]              mag_a, mag_b;
   logic [W-1:0]              rem_vec, quo_vec;
   logic [W:0]                borrow;
   logic [W-1:0]              q_fix, r_fix;

   assign req_fire = req_valid && req_ready;

   // operand magnitudes; a zero divisor loads the raw dividend with no signs
   always_comb begin
      in_dz     = (req_data.divisor == '0);
      in_signed = (req_data.opcode == idm_pkg::OP_SIGNED) && !in_dz;
      in_neg_a  = in_signed && ((req_data.dividend & idm_pkg::SIGN_MASK) != '0);
      in_neg_b  = in_signed && ((req_data.divisor & idm_pkg::SIGN_MASK) != '0);
      mag_a     = in_neg_a ? (~req_data.dividend + W'(1)) : req_data.dividend;
      mag_b     = in_neg_b ? (~req_data.divisor + W'(1)) : req_data.divisor;
   end

   // row of bit cells; bit 0 takes the quotient MSB as its shifted remainder bit
   assign borrow[0]    = 1'b0;
   assign ctrl.load    = req_fire;
   assign ctrl.step    = (state_ff == idm_pkg::ST_RUN);
   assign ctrl.success = rem_vec[W-1] | ~borrow[W];

   for (genvar i = 0; i < W; i++) begin : g_cell
      logic rem_shift, quo_shift;
      if (i == 0) begin : g_lsb
         assign rem_shift = quo_vec[W-1];
         assign quo_shift = ctrl.success;
      end else begin : g_mid
         assign rem_shift = rem_vec[i-1];
         assign quo_shift = quo_vec[i-1];
      end
      idm_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .ld_quo     (mag_a[i]),
         .ld_div     (mag_b[i]),
         .rem_in     (rem_shift),
         .quo_in     (quo_shift),
         .borrow_in  (borrow[i]),
         .rem_out    (rem_vec[i]),
         .quo_out    (quo_vec[i]),
         .borrow_out (borrow[i+1])
      );
   end

   // sign fix-up of the raw magnitudes
   assign q_fix = neg_q_ff ? (~quo_vec + W'(1)) : quo_vec;
   assign r_fix = neg_r_ff ? (~rem_vec + W'(1)) : rem_vec;

   // sequencer: next state, counter, result register
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      neg_q_in     = neg_q_ff;
      neg_r_in     = neg_r_ff;
      dz_in        = dz_ff;
      req_ready    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         idm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = idm_pkg::ST_RUN;
               cnt_in   = '0;
               neg_q_in = in_neg_a ^ in_neg_b;
               neg_r_in = in_neg_a;
               dz_in    = in_dz;
            end
         end
         idm_pkg::ST_RUN: begin
            cnt_in = cnt_ff + idm_pkg::CNT_W'(1);
            if (cnt_ff == idm_pkg::CNT_W'(W - 1)) begin
               state_in = idm_pkg::ST_FIX;
            end
         end
         idm_pkg::ST_FIX: begin
            // wait for the output slot to be free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.quotient        = dz_ff ? '0 : q_fix;
               rsp_data_in.remainder       = r_fix;
               rsp_data_in.divide_by_zero  = dz_ff;
               state_in                    = idm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = idm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= idm_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      neg_q_ff    <= neg_q_in;
      neg_r_ff    <= neg_r_in;
      dz_ff       <= dz_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/idm_checker.sv
// Port-level checks for integer_divide_modulo, bound to the top level.
// Depends on idm_pkg and the top-level port list.
module idm_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input idm_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input idm_pkg::rsp_type rsp_data
);

   // a stalled request beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request beat changed while stalled");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // one item at a time: busy right after accepting a beat
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while divide in progress");

   // zero divisor always reports a zero quotient
   a_dz_quot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_by_zero |-> rsp_data.quotient == '0)
      else $error("divide by zero with nonzero quotient");

   // reset empties the output slot
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind integer_divide_modulo idm_checker u_idm_checker (.*);

// File: dv/integer_divide_modulo_tb.sv
// Self-checking testbench for integer_divide_modulo: corner operands, random traffic
// under changing idle patterns, and a long response hold-off that backs up the input.
// Depends on idm_pkg and the integer_divide_modulo RTL.
`timescale 1ns / 1ps

module integer_divide_modulo_tb;
   import idm_pkg::*;

   localparam int W            = DATA_WIDTH;
   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = W + 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int MAX_REPORTS  = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // idle rates in percent, set per phase
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;

   // results still owed by the block, with the operands that caused them
   rsp_type division_due[$];
   req_type operands_due[$];

   int unsigned mismatches   = 0;
   int unsigned checked      = 0;
   int unsigned signed_beats = 0;
   int unsigned zero_divs    = 0;
   int unsigned cycles       = 0;
   int unsigned input_stalls = 0;

   // hold-off handshake between the test and the receiver
   int unsigned hold_requested = 0;
   int unsigned hold_taken     = 0;
   int unsigned hold_left      = 0;

   integer_divide_modulo dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // truncating division on magnitudes, signs applied afterwards
   function automatic rsp_type predict_division(req_type item);
      logic [W-1:0] num, den, mag_num, mag_den, quo, rem;
      logic         neg_num, neg_den;
      rsp_type      res;
      num = item.dividend;
      den = item.divisor;
      if (den == '0) begin
         res.quotient       = '0;
         res.remainder      = num;
         res.divide_by_zero = 1'b1;
         return res;
      end
      neg_num = (item.opcode == OP_SIGNED) && num[W-1];
      neg_den = (item.opcode == OP_SIGNED) && den[W-1];
      mag_num = neg_num ? (~num + 1'b1) : num;
      mag_den = neg_den ? (~den + 1'b1) : den;
      quo = mag_num / mag_den;
      rem = mag_num % mag_den;
      if (neg_num != neg_den) quo = ~quo + 1'b1;
      if (neg_num) rem = ~rem + 1'b1;
      res.quotient       = quo;
      res.remainder      = rem;
      res.divide_by_zero = 1'b0;
      return res;
   endfunction

   function automatic req_type make_req(opcode_type op, logic [W-1:0] num, logic [W-1:0] den);
      req_type item;
      item.opcode   = op;
      item.dividend = num;
      item.divisor  = den;
      return item;
   endfunction

   function automatic logic [W-1:0] rand_word();
      return W'({$urandom, $urandom});
   endfunction

   function automatic logic [W-1:0] special_word();
      case ($urandom_range(0, 6))
         0: return '0;
         1: return W'(1);
         2: return MAX_POS;
         3: return SIGN_MASK;
         4: return '1;
         5: return W'(2);
         default: return SIGN_MASK | W'(1);
      endcase
   endfunction

   // operand mix: mostly random, plus shapes that hit short quotients and edges
   function automatic req_type random_req();
      logic [W-1:0] num, den;
      opcode_type   op;
      op  = opcode_type'($urandom_range(0, 1));
      num = rand_word();
      den = rand_word();
      case ($urandom_range(0, 9))
         4: den = $urandom_range(0, 1) ? W'($urandom_range(1, 15)) : -W'($urandom_range(1, 15));
         5: den = num >> $urandom_range(0, W - 1);
         6: begin
            num = special_word();
            den = special_word();
         end
         7: num = W'($urandom_range(0, 255));
         8: den = $urandom_range(0, 1) ? '0 : '1;
         9: den = num + W'($urandom_range(0, 3)) - W'(1);
         default: ;
      endcase
      return make_req(op, num, den);
   endfunction

   // one beat on the request channel; valid stays up into the next beat unless an idle gap falls
   task automatic send_beat(req_type item);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      division_due.push_back(predict_division(item));
      operands_due.push_back(item);
      if (item.opcode == OP_SIGNED) signed_beats++;
      if (item.divisor == '0) zero_divs++;
   endtask

   task automatic test_corner_cases();
      send_beat(make_req(OP_UNSIGNED, '0, '0));
      send_beat(make_req(OP_SIGNED, '0, '0));
      send_beat(make_req(OP_UNSIGNED, '1, '0));
      send_beat(make_req(OP_SIGNED, SIGN_MASK, '0));
      send_beat(make_req(OP_SIGNED, W'(12345), '0));
      send_beat(make_req(OP_SIGNED, SIGN_MASK, '1));
      send_beat(make_req(OP_UNSIGNED, SIGN_MASK, '1));
      send_beat(make_req(OP_SIGNED, SIGN_MASK, W'(1)));
      send_beat(make_req(OP_SIGNED, SIGN_MASK, SIGN_MASK));
      send_beat(make_req(OP_SIGNED, MAX_POS, SIGN_MASK));
      send_beat(make_req(OP_UNSIGNED, '0, W'(7)));
      send_beat(make_req(OP_SIGNED, '0, '1));
      send_beat(make_req(OP_UNSIGNED, '1, '1));
      send_beat(make_req(OP_UNSIGNED, '1, W'(1)));
      send_beat(make_req(OP_SIGNED, '1, '1));
      send_beat(make_req(OP_SIGNED, MAX_POS, '1));
      send_beat(make_req(OP_SIGNED, -W'(7), W'(2)));
      send_beat(make_req(OP_SIGNED, W'(7), -W'(2)));
      send_beat(make_req(OP_SIGNED, -W'(7), -W'(2)));
      send_beat(make_req(OP_UNSIGNED, W'(3), W'(10)));
      send_beat(make_req(OP_SIGNED, -W'(3), W'(10)));
      send_beat(make_req(OP_UNSIGNED, MAX_POS, SIGN_MASK));
      send_beat(make_req(OP_UNSIGNED, '1, MAX_POS));
   endtask

   task automatic test_random_traffic(int unsigned beats, int unsigned snd_idle,
                                      int unsigned rcv_idle);
      req_idle_pct = snd_idle;
      rsp_idle_pct = rcv_idle;
      repeat (beats) send_beat(random_req());
   endtask

   // receiver holds off while requests keep coming, so the block backs up
   task automatic test_backpressure_fill();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_requested++;
      repeat (12) send_beat(random_req());
   endtask

   // receiver: random idling, or a counted hold-off when one is asked for
   always @(posedge clock) begin
      if (hold_taken != hold_requested) begin
         hold_taken = hold_requested;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // result checker against the oldest prediction
   always @(posedge clock) begin
      rsp_type exp_rsp;
      req_type src;
      if (!reset && rsp_valid && rsp_ready) begin
         if (division_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result beat: q=%h r=%h dz=%b",
                        rsp_data.quotient, rsp_data.remainder, rsp_data.divide_by_zero);
         end else begin
            exp_rsp = division_due.pop_front();
            src     = operands_due.pop_front();
            checked++;
            if (rsp_data.quotient !== exp_rsp.quotient
                || rsp_data.remainder !== exp_rsp.remainder
                || rsp_data.divide_by_zero !== exp_rsp.divide_by_zero) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("mismatch op=%s a=%h b=%h: exp q=%h r=%h dz=%b, got q=%h r=%h dz=%b",
                           src.opcode.name(), src.dividend, src.divisor,
                           exp_rsp.quotient, exp_rsp.remainder, exp_rsp.divide_by_zero,
                           rsp_data.quotient, rsp_data.remainder, rsp_data.divide_by_zero);
            end
         end
      end
   end

   // cycle limit and input stall count
   always @(posedge clock) begin
      cycles++;
      if (req_valid && !req_ready) input_stalls++;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, division_due.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_cases();
      test_random_traffic(320, 20, 56);
      test_random_traffic(320, 56, 20);
      test_backpressure_fill();
      test_random_traffic(300, 0, 0);
      req_valid <= 1'b0;

      // drain
      while (division_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d quotient/remainder results (%0d signed, %0d zero divisors)",
               checked, signed_beats, zero_divs);
      $display("idle patterns on both sides, one %0d-cycle response hold-off, %0d input stall cycles",
               HOLD_CYCLES, input_stalls);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
